>>> rtl/trcs_pkg.sv
package trcs_pkg;

  localparam int unsigned TYPE_W   = 32;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned HDR_BYTES = 8;

  // Item actions.
  localparam logic [1:0] ACT_CLEAR    = 2'd0;
  localparam logic [1:0] ACT_PUT_HDR  = 2'd1;
  localparam logic [1:0] ACT_PUT_DATA = 2'd2;
  localparam logic [1:0] ACT_GET      = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_CLEARED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_PUT      = 3'd4;

  // Store state as shown on the result.
  localparam logic signed [1:0] STATE_UNCLEARED = -2'sd1;
  localparam logic signed [1:0] STATE_CLEARED   = 2'sd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_HDR,
    S_PAD,
    S_COMMIT,
    S_GET_CHECK,
    S_GET_READ,
    S_GET_EVAL,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CLOSE,
    OP_SET_STATUS,
    OP_HDR_OPEN,
    OP_HDR_BYTE,
    OP_DATA,
    OP_PAD,
    OP_COMMIT,
    OP_GET_START,
    OP_GET_READ,
    OP_GET_NEXT,
    OP_FOUND
  } dp_op_e;

  typedef struct packed {
    logic                latch;
    logic                load;
    dp_op_e              op;
    logic [STATUS_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       present;
    logic       fits;
    logic       put_open;
    logic       rem_one;
    logic       pend_odd;
    logic       len_zero;
    logic       hdr_last;
    logic       rd_done;
    logic       get_more;
    logic       type_match;
    logic       len_bad;
  } dp_stat_t;

endpackage

>>> rtl/typed_record_clipboard_store.sv
// Typed record store: a byte memory of STORE_BYTES holding appended records
// (4-byte type, 4-byte length, both big-endian, the data, and a zero pad byte
// after odd-length data). Each request carries one action: clear, put header,
// put data byte or get by type, and returns exactly one result with status,
// match length and data offset, committed size, clear count and store state.
// A record counts toward used_size only once its last data byte has arrived.
// Requests are handled one at a time through a byte memory with one write
// port and one registered read port, so work goes byte at a time: a clear, a
// refused header or a data byte passes through execute and finish, a data
// byte that closes a record adds a commit step (and a pad write before it
// for odd-length data), an accepted header writes its 8 header bytes one per
// cycle (a zero-length record then commits at once), and a get walks the
// committed records, reading each header byte by byte and comparing its type.
// The next request is taken while the previous result waits in the output
// register; a full, stalled output register holds the block in its finish
// state. The memory needs no clearing pass: only bytes of committed records
// are ever read.
module typed_record_clipboard_store
  import trcs_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [TYPE_W-1:0]          entry_type_i,
  input  logic [LEN_W-1:0]           entry_length_i,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [LEN_W-1:0]           found_length_o,
  output logic [LEN_W-1:0]           data_offset_o,
  output logic [LEN_W-1:0]           used_size_o,
  output logic [COUNT_W-1:0]         change_count_o,
  output logic signed [1:0]          store_state_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic                out_valid_q;
  logic                out_free;
  logic [STATUS_W-1:0] dp_status;
  logic [LEN_W-1:0]    dp_flen;
  logic [LEN_W-1:0]    dp_doff;
  logic [LEN_W-1:0]    dp_used;
  logic [COUNT_W-1:0]  dp_count;
  logic                dp_present;

  logic [STATUS_W-1:0] status_q;
  logic [LEN_W-1:0]    flen_q;
  logic [LEN_W-1:0]    doff_q;
  logic [LEN_W-1:0]    used_q;
  logic [COUNT_W-1:0]  count_q;
  logic signed [1:0]   state_q;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  trcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  trcs_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .entry_type_i   (entry_type_i),
    .entry_length_i (entry_length_i),
    .data_byte_i    (data_byte_i),
    .stat_o         (stat),
    .status_o       (dp_status),
    .found_length_o (dp_flen),
    .data_offset_o  (dp_doff),
    .used_size_o    (dp_used),
    .change_count_o (dp_count),
    .present_o      (dp_present)
  );

  // Hold the valid flag until the consumer takes the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the finished result; the datapath may start the next request at
  // the same edge, which only touches its registers after this sample.
  always_ff @(posedge clk_i) begin
    if (cmd.load) begin
      status_q <= dp_status;
      flen_q   <= dp_flen;
      doff_q   <= dp_doff;
      used_q   <= dp_used;
      count_q  <= dp_count;
      state_q  <= dp_present ? STATE_CLEARED : STATE_UNCLEARED;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_length_o = flen_q;
  assign data_offset_o  = doff_q;
  assign used_size_o    = used_q;
  assign change_count_o = count_q;
  assign store_state_o  = state_q;

endmodule

>>> rtl/trcs_ctrl.sv
module trcs_ctrl
  import trcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_free_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat_i.action)
          ACT_CLEAR: state_d = S_FINISH;
          ACT_PUT_HDR: begin
            if (stat_i.present && stat_i.fits) state_d = S_HDR;
            else state_d = S_FINISH;
          end
          ACT_PUT_DATA: begin
            priority if (stat_i.put_open && stat_i.rem_one && stat_i.pend_odd) state_d = S_PAD;
            else if (stat_i.put_open && stat_i.rem_one) state_d = S_COMMIT;
            else state_d = S_FINISH;
          end
          ACT_GET: begin
            if (stat_i.present) state_d = S_GET_CHECK;
            else state_d = S_FINISH;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_HDR: begin
        if (stat_i.hdr_last) state_d = stat_i.len_zero ? S_COMMIT : S_FINISH;
      end
      S_PAD:       state_d = S_COMMIT;
      S_COMMIT:    state_d = S_FINISH;
      S_GET_CHECK: state_d = stat_i.get_more ? S_GET_READ : S_FINISH;
      S_GET_READ: begin
        if (stat_i.rd_done) state_d = S_GET_EVAL;
      end
      S_GET_EVAL: begin
        priority if (stat_i.type_match || stat_i.len_bad) state_d = S_FINISH;
        else state_d = S_GET_CHECK;
      end
      S_FINISH: begin
        if (out_free_i) state_d = in_valid_i ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o      = '{latch: 1'b0, load: 1'b0, op: OP_NONE, code: ST_OK};
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      S_EXEC: begin
        unique case (stat_i.action)
          ACT_CLEAR: cmd_o.op = OP_CLEAR;
          ACT_PUT_HDR: begin
            priority if (!stat_i.present) begin
              cmd_o.op   = OP_CLOSE;
              cmd_o.code = ST_NOT_CLEARED;
            end else if (!stat_i.fits) begin
              cmd_o.op   = OP_CLOSE;
              cmd_o.code = ST_NO_SPACE;
            end else begin
              cmd_o.op = OP_HDR_OPEN;
            end
          end
          ACT_PUT_DATA: begin
            if (stat_i.put_open) begin
              cmd_o.op = OP_DATA;
            end else begin
              cmd_o.op   = OP_SET_STATUS;
              cmd_o.code = ST_NO_PUT;
            end
          end
          ACT_GET: begin
            if (stat_i.present) begin
              cmd_o.op = OP_GET_START;
            end else begin
              cmd_o.op   = OP_SET_STATUS;
              cmd_o.code = ST_NOT_CLEARED;
            end
          end
          default: cmd_o.op = OP_NONE;
        endcase
      end
      S_HDR:       cmd_o.op = OP_HDR_BYTE;
      S_PAD:       cmd_o.op = OP_PAD;
      S_COMMIT:    cmd_o.op = OP_COMMIT;
      S_GET_CHECK: cmd_o.op = OP_NONE;
      S_GET_READ:  cmd_o.op = OP_GET_READ;
      S_GET_EVAL: begin
        priority if (stat_i.type_match) cmd_o.op = OP_FOUND;
        else if (stat_i.len_bad) cmd_o.op = OP_NONE;
        else cmd_o.op = OP_GET_NEXT;
      end
      S_FINISH: begin
        in_stall_o  = !out_free_i;
        cmd_o.load  = out_free_i;
        cmd_o.latch = out_free_i && in_valid_i;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/trcs_datapath.sv
module trcs_datapath
  import trcs_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [1:0]          action_i,
  input  logic [TYPE_W-1:0]   entry_type_i,
  input  logic [LEN_W-1:0]    entry_length_i,
  input  logic [7:0]          data_byte_i,
  output dp_stat_t            stat_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [LEN_W-1:0]    found_length_o,
  output logic [LEN_W-1:0]    data_offset_o,
  output logic [LEN_W-1:0]    used_size_o,
  output logic [COUNT_W-1:0]  change_count_o,
  output logic                present_o
);

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned SIZE_W = $clog2(STORE_BYTES + 1);
  localparam int unsigned PTR_W  = SIZE_W + 2;
  localparam int unsigned SUM_W  = $clog2(STORE_BYTES + 2 ** LEN_W + HDR_BYTES + 2);
  localparam int unsigned HDR_W  = 8 * HDR_BYTES;

  logic [7:0] store_mem [STORE_BYTES];

  // Control state.
  logic [SIZE_W-1:0]  committed_q;
  logic               present_q;
  logic [COUNT_W-1:0] clear_cnt_q;
  logic               put_open_q;
  logic [SIZE_W-1:0]  wp_q;
  logic [LEN_W-1:0]   remaining_q;
  logic [LEN_W-1:0]   pending_q;
  logic [3:0]         cnt_q;

  // Item and walk payload.
  logic [1:0]          action_q;
  logic [TYPE_W-1:0]   etype_q;
  logic [LEN_W-1:0]    elen_q;
  logic [7:0]          dbyte_q;
  logic [STATUS_W-1:0] status_q;
  logic [LEN_W-1:0]    flen_q;
  logic [LEN_W-1:0]    doff_q;
  logic [HDR_W-1:0]    hdr_q;
  logic [PTR_W-1:0]    p_q;
  logic [7:0]          rd_q;

  logic [SUM_W-1:0]  fit_sum;
  logic [31:0]       hdr_len;
  logic [PTR_W-1:0]  p_next;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [SIZE_W-1:0] commit_size;

  assign fit_sum = SUM_W'(committed_q) + SUM_W'(HDR_BYTES) + SUM_W'(elen_q)
                 + SUM_W'(elen_q[0]);
  assign hdr_len = hdr_q[31:0];
  assign p_next  = p_q + PTR_W'(HDR_BYTES) + PTR_W'(hdr_len[SIZE_W-1:0])
                 + PTR_W'(hdr_len[0]);
  assign rd_ptr    = p_q + PTR_W'(cnt_q);
  assign mem_raddr = rd_ptr[ADDR_W-1:0];
  assign commit_size = committed_q + SIZE_W'(HDR_BYTES) + SIZE_W'(pending_q)
                     + SIZE_W'(pending_q[0]);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = dbyte_q;
    unique case (cmd_i.op)
      OP_HDR_BYTE: begin
        mem_we    = 1'b1;
        mem_wdata = hdr_q[HDR_W-1 -: 8];
      end
      OP_DATA: mem_we = 1'b1;
      OP_PAD: begin
        mem_we    = 1'b1;
        mem_wdata = 8'h00;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[wp_q[ADDR_W-1:0]] <= mem_wdata;
    rd_q <= store_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= '0;
      present_q   <= 1'b0;
      clear_cnt_q <= '0;
      put_open_q  <= 1'b0;
      wp_q        <= '0;
      remaining_q <= '0;
      pending_q   <= '0;
      cnt_q       <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_CLEAR: begin
          committed_q <= '0;
          present_q   <= 1'b1;
          clear_cnt_q <= clear_cnt_q + 1'b1;
          put_open_q  <= 1'b0;
          remaining_q <= '0;
        end
        OP_CLOSE: begin
          put_open_q  <= 1'b0;
          remaining_q <= '0;
        end
        OP_HDR_OPEN: begin
          wp_q        <= committed_q;
          pending_q   <= elen_q;
          remaining_q <= elen_q;
          put_open_q  <= 1'b1;
          cnt_q       <= '0;
        end
        OP_HDR_BYTE: begin
          wp_q  <= wp_q + 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
        OP_DATA: begin
          wp_q        <= wp_q + 1'b1;
          remaining_q <= remaining_q - 1'b1;
        end
        OP_COMMIT: begin
          committed_q <= commit_size;
          put_open_q  <= 1'b0;
          remaining_q <= '0;
        end
        OP_GET_START, OP_GET_NEXT: cnt_q <= '0;
        OP_GET_READ: cnt_q <= cnt_q + 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      etype_q  <= entry_type_i;
      elen_q   <= entry_length_i;
      dbyte_q  <= data_byte_i;
      status_q <= ST_OK;
      flen_q   <= '0;
      doff_q   <= '0;
    end
    unique case (cmd_i.op)
      OP_CLOSE, OP_SET_STATUS: status_q <= cmd_i.code;
      OP_HDR_OPEN: hdr_q <= {etype_q, 32'(elen_q)};
      OP_HDR_BYTE: hdr_q <= {hdr_q[HDR_W-9:0], 8'h00};
      OP_GET_START: begin
        p_q      <= '0;
        status_q <= ST_NOT_FOUND;
      end
      OP_GET_READ: begin
        if (cnt_q != 4'd0) hdr_q <= {hdr_q[HDR_W-9:0], rd_q};
      end
      OP_GET_NEXT: p_q <= p_next;
      OP_FOUND: begin
        status_q <= ST_OK;
        flen_q   <= hdr_len[LEN_W-1:0];
        doff_q   <= LEN_W'(p_q + PTR_W'(HDR_BYTES));
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.action     = action_q;
    stat_o.present    = present_q;
    stat_o.fits       = fit_sum <= SUM_W'(STORE_BYTES);
    stat_o.put_open   = put_open_q;
    stat_o.rem_one    = remaining_q == LEN_W'(1);
    stat_o.pend_odd   = pending_q[0];
    stat_o.len_zero   = pending_q == '0;
    stat_o.hdr_last   = cnt_q == 4'(HDR_BYTES - 1);
    stat_o.rd_done    = cnt_q == 4'(HDR_BYTES);
    stat_o.get_more   = p_q < PTR_W'(committed_q);
    stat_o.type_match = hdr_q[HDR_W-1 -: TYPE_W] == etype_q;
    stat_o.len_bad    = hdr_len > 32'(STORE_BYTES);
  end

  assign status_o       = status_q;
  assign found_length_o = flen_q;
  assign data_offset_o  = doff_q;
  assign used_size_o    = LEN_W'(committed_q);
  assign change_count_o = clear_cnt_q;
  assign present_o      = present_q;

endmodule

>>> rtl/trcs_checker.sv
module trcs_checker
  import trcs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [1:0]          action_i,
  input logic [TYPE_W-1:0]   entry_type_i,
  input logic [LEN_W-1:0]    entry_length_i,
  input logic [7:0]          data_byte_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [LEN_W-1:0]    found_length_o,
  input logic [LEN_W-1:0]    data_offset_o,
  input logic [LEN_W-1:0]    used_size_o,
  input logic [COUNT_W-1:0]  change_count_o,
  input logic signed [1:0]   store_state_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(found_length_o)
      && $stable(data_offset_o) && $stable(used_size_o) && $stable(change_count_o))
    else $error("result payload changed while stalled");

  // Before the first clear nothing can be committed or counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_state_o == STATE_UNCLEARED |->
      used_size_o == '0 && change_count_o == '0)
    else $error("uncleared store reports contents");

  // Only a successful get reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> found_length_o == '0 && data_offset_o == '0)
    else $error("match fields set on a failed request");

endmodule

bind typed_record_clipboard_store trcs_checker u_trcs_checker (.*);

>>> tb/typed_record_clipboard_store_test.sv
module typed_record_clipboard_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  import trcs_pkg::*;

  localparam int unsigned STORE_BYTES  = 4096;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned MAX_RECORDS  = 24;     // keeps every get walk short
  localparam int unsigned LONG_HOLD    = 400;    // receiver back-pressure burst
  localparam int unsigned DRAIN_CYCLES = 300;    // longer than a get over MAX_RECORDS
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned PRINT_CAP    = 40;

  // Record types used to make gets hit.
  localparam logic [TYPE_W-1:0] T_ZERO = 32'h0000_0000;
  localparam logic [TYPE_W-1:0] T_ALL1 = 32'hFFFF_FFFF;
  localparam logic [TYPE_W-1:0] T_TEXT = 32'h5445_5854;
  localparam logic [TYPE_W-1:0] T_PICT = 32'h5049_4354;
  localparam logic [TYPE_W-1:0] T_STYL = 32'h7374_796C;
  localparam logic [TYPE_W-1:0] T_ODD  = 32'h8000_0001;

  typedef struct packed {
    logic [1:0]        action;
    logic [TYPE_W-1:0] etype;
    logic [LEN_W-1:0]  elen;
    logic [7:0]        dbyte;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    flen;
    logic [LEN_W-1:0]    doff;
    logic [LEN_W-1:0]    used;
    logic [COUNT_W-1:0]  count;
    logic [1:0]          state;
  } reply_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [TYPE_W-1:0] etype;
    logic [LEN_W-1:0]  elen;
    logic [7:0]        dbyte;
    logic              typed;   // expected reply spelled out below, else predicted
    reply_t            want;
  } drill_row_t;

  // Replies that can be read straight off the spec.
  localparam reply_t NO_WANT         = '0;
  localparam reply_t PRE_NOT_CLEARED = '{ST_NOT_CLEARED, 13'd0, 13'd0, 13'd0, 16'd0,
                                         STATE_UNCLEARED};
  localparam reply_t PRE_NO_PUT      = '{ST_NO_PUT, 13'd0, 13'd0, 13'd0, 16'd0,
                                         STATE_UNCLEARED};
  localparam reply_t EMPTY_OK        = '{ST_OK, 13'd0, 13'd0, 13'd0, 16'd1, STATE_CLEARED};
  localparam reply_t EMPTY_NOT_FOUND = '{ST_NOT_FOUND, 13'd0, 13'd0, 13'd0, 16'd1,
                                         STATE_CLEARED};
  localparam reply_t EMPTY_NO_SPACE  = '{ST_NO_SPACE, 13'd0, 13'd0, 13'd0, 16'd1,
                                         STATE_CLEARED};
  localparam reply_t EMPTY_NO_PUT    = '{ST_NO_PUT, 13'd0, 13'd0, 13'd0, 16'd1,
                                         STATE_CLEARED};
  localparam reply_t ONE_REC_OK      = '{ST_OK, 13'd0, 13'd0, 13'd8, 16'd1, STATE_CLEARED};

  localparam int unsigned DRILL_ROWS = 26;

  // Directed requests: uncleared store, fit boundaries from an empty store, a dropped
  // huge put, a zero-length record, odd and even records with an interrupted put,
  // gets on every type present and one absent, an exact fit, clear over an open put.
  drill_row_t drill_tab [DRILL_ROWS] = '{
    '{ACT_GET,      T_ZERO,       13'd0,    8'h00, 1'b1, PRE_NOT_CLEARED},
    '{ACT_PUT_HDR,  T_ALL1,       13'd4096, 8'h00, 1'b1, PRE_NOT_CLEARED},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'hFF, 1'b1, PRE_NO_PUT},
    '{ACT_CLEAR,    T_ZERO,       13'd0,    8'h00, 1'b1, EMPTY_OK},
    '{ACT_GET,      T_TEXT,       13'd0,    8'h00, 1'b1, EMPTY_NOT_FOUND},
    '{ACT_PUT_HDR,  T_ALL1,       13'd4096, 8'h00, 1'b1, EMPTY_NO_SPACE},
    '{ACT_PUT_HDR,  T_TEXT,       13'd4088, 8'h00, 1'b1, EMPTY_OK},
    '{ACT_PUT_HDR,  T_PICT,       13'd4095, 8'h00, 1'b1, EMPTY_NO_SPACE},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'h00, 1'b1, EMPTY_NO_PUT},
    '{ACT_PUT_HDR,  T_TEXT,       13'd4087, 8'h00, 1'b1, EMPTY_OK},
    '{ACT_PUT_HDR,  T_ZERO,       13'd0,    8'h00, 1'b1, ONE_REC_OK},
    '{ACT_PUT_HDR,  T_ALL1,       13'd3,    8'h00, 1'b0, NO_WANT},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'hFF, 1'b0, NO_WANT},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'h00, 1'b0, NO_WANT},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'hA5, 1'b0, NO_WANT},
    '{ACT_PUT_HDR,  T_TEXT,       13'd2,    8'h00, 1'b0, NO_WANT},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'h5A, 1'b0, NO_WANT},
    '{ACT_PUT_HDR,  T_PICT,       13'd1,    8'h00, 1'b0, NO_WANT},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'h01, 1'b0, NO_WANT},
    '{ACT_GET,      T_ALL1,       13'd0,    8'h00, 1'b0, NO_WANT},
    '{ACT_GET,      T_ZERO,       13'd0,    8'h00, 1'b0, NO_WANT},
    '{ACT_GET,      T_PICT,       13'd0,    8'h00, 1'b0, NO_WANT},
    '{ACT_GET,      T_TEXT,       13'd0,    8'h00, 1'b0, NO_WANT},
    '{ACT_PUT_HDR,  32'h1234_5678, 13'd4058, 8'h00, 1'b0, NO_WANT},
    '{ACT_CLEAR,    T_ZERO,       13'd0,    8'h00, 1'b0, NO_WANT},
    '{ACT_PUT_DATA, T_ZERO,       13'd0,    8'h7E, 1'b0, NO_WANT}
  };

  localparam logic [TYPE_W-1:0] TYPE_POOL [6] = '{T_ZERO, T_ALL1, T_TEXT, T_PICT,
                                                  T_STYL, T_ODD};

  // DUT ports; every input starts at a known value.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i       = ACT_CLEAR;
  logic [TYPE_W-1:0]   entry_type_i   = '0;
  logic [LEN_W-1:0]    entry_length_i = '0;
  logic [7:0]          data_byte_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [LEN_W-1:0]    found_length_o;
  logic [LEN_W-1:0]    data_offset_o;
  logic [LEN_W-1:0]    used_size_o;
  logic [COUNT_W-1:0]  change_count_o;
  logic signed [1:0]   store_state_o;

  // Shadow copy of the store, advanced once per accepted request.
  logic [7:0]         shadow_bytes [STORE_BYTES];
  int unsigned        shadow_used    = 0;
  int unsigned        shadow_wptr    = 0;
  int unsigned        shadow_left    = 0;
  int unsigned        shadow_pend    = 0;
  int unsigned        shadow_records = 0;
  bit                 shadow_present = 1'b0;
  bit                 shadow_open    = 1'b0;
  logic [COUNT_W-1:0] shadow_clears  = '0;
  logic [1:0]         shadow_flag    = STATE_UNCLEARED;

  reply_t      replies_due [$];     // expected replies, oldest first
  int unsigned mismatches    = 0;
  int unsigned replies_seen  = 0;
  int unsigned work_items    = 0;   // requests the block did not simply ignore
  int unsigned cycle_count   = 0;
  bit          tx_up         = 1'b0;
  bit          calm_stretch  = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;

  typed_record_clipboard_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .entry_type_i  (entry_type_i),
    .entry_length_i(entry_length_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_length_o(found_length_o),
    .data_offset_o (data_offset_o),
    .used_size_o   (used_size_o),
    .change_count_o(change_count_o),
    .store_state_o (store_state_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Byte accesses past the end of the store drop writes and read back zero.
  function automatic void poke_byte(int unsigned addr, logic [7:0] v);
    if (addr < STORE_BYTES) shadow_bytes[addr] = v;
  endfunction

  function automatic void poke_word(int unsigned addr, logic [31:0] v);
    for (int k = 0; k < 4; k++) poke_byte(addr + k, v[31 - 8*k -: 8]);
  endfunction

  function automatic logic [31:0] peek_word(int unsigned addr);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++)
      w = {w[23:0], (addr + k < STORE_BYTES) ? shadow_bytes[addr + k] : 8'h00};
    return w;
  endfunction

  // Close the open put: write the pad for odd data and count the record as used.
  function automatic void seal_record();
    int unsigned pad;
    pad = shadow_pend & 1;
    if (pad != 0) poke_byte(shadow_wptr, 8'h00);
    shadow_used    += HDR_BYTES + shadow_pend + pad;
    shadow_open    = 1'b0;
    shadow_left    = 0;
    shadow_records += 1;
  endfunction

  // Work out the reply to one request and move the shadow store on.
  function automatic reply_t predict_reply(request_t rq);
    reply_t      rp;
    int unsigned need;
    int unsigned p;
    logic [31:0] rec_type;
    logic [31:0] rec_len;
    rp        = '0;
    rp.status = ST_OK;
    case (rq.action)
      ACT_CLEAR: begin
        shadow_used    = 0;
        shadow_present = 1'b1;
        shadow_clears  += 1'b1;
        shadow_flag    = STATE_CLEARED;
        shadow_open    = 1'b0;
        shadow_left    = 0;
        shadow_records = 0;
      end
      ACT_PUT_HDR: begin
        // any unfinished put is dropped, never committed
        shadow_open = 1'b0;
        shadow_left = 0;
        need = shadow_used + HDR_BYTES + rq.elen + rq.elen[0];
        if (!shadow_present) begin
          rp.status = ST_NOT_CLEARED;
        end else if (need > STORE_BYTES) begin
          rp.status = ST_NO_SPACE;
        end else begin
          poke_word(shadow_used, rq.etype);
          poke_word(shadow_used + 4, 32'(rq.elen));
          shadow_wptr = shadow_used + HDR_BYTES;
          shadow_pend = 32'(rq.elen);
          shadow_left = 32'(rq.elen);
          shadow_open = 1'b1;
          if (rq.elen == 0) seal_record();
        end
      end
      ACT_PUT_DATA: begin
        if (!shadow_open) begin
          rp.status = ST_NO_PUT;
        end else begin
          poke_byte(shadow_wptr, rq.dbyte);
          shadow_wptr += 1;
          shadow_left -= 1;
          if (shadow_left == 0) seal_record();
        end
      end
      ACT_GET: begin
        if (!shadow_present) begin
          rp.status = ST_NOT_CLEARED;
        end else begin
          // walk committed records from the start, first type match wins
          rp.status = ST_NOT_FOUND;
          p = 0;
          while (p < shadow_used) begin
            rec_type = peek_word(p);
            rec_len  = peek_word(p + 4);
            if (rec_type == rq.etype) begin
              rp.flen   = LEN_W'(rec_len);
              rp.doff   = LEN_W'(p + HDR_BYTES);
              rp.status = ST_OK;
              break;
            end
            if (rec_len > STORE_BYTES) break;
            p += HDR_BYTES + rec_len + (rec_len & 1);
          end
        end
      end
    endcase
    rp.used  = LEN_W'(shadow_used);
    rp.count = shadow_clears;
    rp.state = shadow_flag;
    return rp;
  endfunction

  // Idle length: mostly none, some short, a few long; none at all in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_stretch || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Record lengths: mostly tiny, sometimes a few dozen, rarely a couple hundred.
  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(0, 6));
    if (r < 95) return LEN_W'($urandom_range(7, 40));
    return LEN_W'($urandom_range(41, 200));
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    return TYPE_POOL[$urandom_range(0, 5)];
  endfunction

  function automatic request_t make_req(logic [1:0] act, logic [TYPE_W-1:0] ty,
                                        logic [LEN_W-1:0] len, logic [7:0] b);
    request_t rq;
    rq.action = act;
    rq.etype  = ty;
    rq.elen   = len;
    rq.dbyte  = b;
    return rq;
  endfunction

  // Drive one request, hold it until taken, then log its reply and maybe idle a while.
  task automatic offer(input request_t rq, input bit typed = 1'b0,
                       input reply_t want = '0);
    reply_t      got;
    int unsigned gap;
    in_valid_i     <= 1'b1;
    action_i       <= rq.action;
    entry_type_i   <= rq.etype;
    entry_length_i <= rq.elen;
    data_byte_i    <= rq.dbyte;
    tx_up = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // advance the shadow even when the reply is spelled out in the table
    got = predict_reply(rq);
    replies_due.push_back(typed ? want : got);
    if (got.status != ST_NO_PUT) work_items++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      tx_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid unless the last request already did so in this step.
  task automatic lower_valid();
    if (tx_up) begin
      in_valid_i <= 1'b0;
      tx_up = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] reply %0d: %s", $time, replies_seen, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Compare every reply the receiver takes against the oldest expectation.
  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("reply with no request waiting");
      end else begin
        want = replies_due.pop_front();
        check_field("status", 16'(status_o), 16'(want.status));
        check_field("found_length", 16'(found_length_o), 16'(want.flen));
        check_field("data_offset", 16'(data_offset_o), 16'(want.doff));
        check_field("used_size", 16'(used_size_o), 16'(want.used));
        check_field("change_count", change_count_o, want.count);
        check_field("store_state", {14'b0, store_state_o}, {14'b0, want.state});
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("typed_record_clipboard_store_test: errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up and
  // stalls its input while the sender keeps offering.
  initial begin : result_side
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_stall_i <= 1'b0;
          @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Sender: reset, directed table, then random record traffic.
  initial begin : request_side
    int          pick;
    int          probe;
    int unsigned cut;
    logic [LEN_W-1:0] len;
    bit          paused;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DRILL_ROWS; i++)
      offer(make_req(drill_tab[i].action, drill_tab[i].etype, drill_tab[i].elen,
                     drill_tab[i].dbyte), drill_tab[i].typed, drill_tab[i].want);

    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      // hold off the receiver once traffic is flowing
      if (!long_hold_req && work_items >= 150) long_hold_req = 1'b1;
      // pause once and let every reply come home before going on
      if (!paused && work_items >= 500) begin
        paused = 1'b1;
        lower_valid();
        while (replies_due.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 19) == 0) calm_stretch = ~calm_stretch;

      pick = $urandom_range(0, 99);
      if (shadow_records >= MAX_RECORDS || pick < 5) begin
        offer(make_req(ACT_CLEAR, $urandom, LEN_W'($urandom), 8'($urandom)));
      end else if (pick < 50) begin
        // well-formed put; now and then abandon it part way
        len = pick_len();
        offer(make_req(ACT_PUT_HDR, pick_type(), len, 8'($urandom)));
        if (shadow_open) begin
          cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32'(len)) : 32'(len);
          for (int unsigned k = 0; k < cut; k++)
            offer(make_req(ACT_PUT_DATA, $urandom, LEN_W'($urandom), 8'($urandom)));
        end else if ($urandom_range(0, 1) == 1) begin
          offer(make_req(ACT_PUT_DATA, $urandom, LEN_W'($urandom), 8'($urandom)));
        end
      end else if (pick < 75) begin
        offer(make_req(ACT_GET, pick_type(), LEN_W'($urandom), 8'($urandom)));
      end else if (pick < 85) begin
        // header right at the space limit: one under, exact, one and two over
        probe = int'(STORE_BYTES) - int'(shadow_used) - int'(HDR_BYTES)
                + int'($urandom_range(0, 3)) - 1;
        if (probe < 0) probe = 0;
        if (probe > int'(STORE_BYTES)) probe = int'(STORE_BYTES);
        offer(make_req(ACT_PUT_HDR, pick_type(), LEN_W'(probe), 8'($urandom)));
        if (shadow_open && probe <= 40)
          for (int k = 0; k < probe; k++)
            offer(make_req(ACT_PUT_DATA, $urandom, LEN_W'($urandom), 8'($urandom)));
      end else if (pick < 92) begin
        // noise: stray data byte or a header of any legal length
        if ($urandom_range(0, 1) == 0)
          offer(make_req(ACT_PUT_DATA, $urandom, LEN_W'($urandom), 8'($urandom)));
        else
          offer(make_req(ACT_PUT_HDR, $urandom, LEN_W'($urandom_range(0, STORE_BYTES)),
                         8'($urandom)));
      end else begin
        offer(make_req(ACT_GET, $urandom, LEN_W'($urandom), 8'($urandom)));
      end
    end

    lower_valid();
    while (replies_due.size() != 0) @(posedge clk_i);
    // watch for stray replies before closing
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("typed_record_clipboard_store_test: clean");
    else
      $display("typed_record_clipboard_store_test: errors");
    $finish;
  end

endmodule
